@@ hdl/ipv6_text_expander_macros.svh @@
// Assertion macros shared by the IPv6 text expander modules.
`ifndef IPV6_TEXT_EXPANDER_MACROS_SVH
`define IPV6_TEXT_EXPANDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPV6TE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ipv6te: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPV6TE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ipv6te: next-cycle check failed");

`endif

@@ hdl/ipv6te_pkg.sv @@
// Package with constants and types of the IPv6 text expander.
`timescale 1ns / 1ps
`default_nettype none
package ipv6te_pkg;

    localparam int GROUP_COUNT      = 8;
    localparam int DIGITS_PER_GROUP = 4;

    localparam int GROUP_W = 32;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 3;
    localparam int SLOT_W  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int COUNT_W = $clog2(GROUP_COUNT + 1);
    localparam int LEN_W   = $clog2(DIGITS_PER_GROUP + 1);
    localparam int TDATA_W = ((GROUP_W + IDX_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0]  CH_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_ZERO    = 8'h30;
    localparam logic [GROUP_W-1:0] ZERO_WORD  = 32'h3030_3030;

    // Finished address handed from the parser to the output buffer.
    typedef struct packed {
        logic                                load;
        logic                                bad;
        logic [GROUP_COUNT-1:0][GROUP_W-1:0] words;
    } ipv6te_result_t;

endpackage
`default_nettype wire

@@ hdl/ipv6te_parser.sv @@
// Input register and character parser that collects the groups of one address.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv6_text_expander_macros.svh"
module ipv6te_parser
    import ipv6te_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CHAR_W-1:0] s_char,
    input  wire logic              buf_free,
    output ipv6te_result_t         result
);

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;

    logic [GROUP_COUNT-1:0][GROUP_W-1:0] head_reg, head_next;
    logic [GROUP_COUNT-1:0][GROUP_W-1:0] tail_reg, tail_next;
    logic [COUNT_W-1:0] head_count_reg, head_count_next;
    logic [COUNT_W-1:0] tail_count_reg, tail_count_next;
    logic [GROUP_W-1:0] chars_reg, chars_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic prev_colon_reg, prev_colon_next;
    logic double_reg, double_next;
    logic err_reg, err_next;

    logic is_colon, is_newline, consume;
    logic close_req, room, close_head, close_tail, close_err;
    logic [GROUP_W-1:0] padded;
    logic [GROUP_COUNT-1:0][GROUP_W-1:0] head_closed, tail_shift;
    logic [COUNT_W-1:0] head_count_closed;
    logic [COUNT_W:0]   count_sum;

    assign is_colon   = (in_char_reg == CH_COLON);
    assign is_newline = (in_char_reg == CH_NEWLINE);
    // A newline needs the output buffer; other characters never wait.
    assign consume    = in_valid_reg && (!is_newline || buf_free);
    assign s_tready   = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (consume) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    // Right-align the current group and pad it with ASCII zeros on the left.
    always_comb begin
        for (int b = 0; b < GROUP_W / CHAR_W; b++) begin
            padded[b*CHAR_W +: CHAR_W] = (b < int'(len_reg)) ?
                chars_reg[b*CHAR_W +: CHAR_W] : CH_ZERO;
        end
    end

    assign close_req = (is_colon && !prev_colon_reg) ||
                       (is_newline && !(double_reg && prev_colon_reg));
    assign count_sum = {1'b0, head_count_reg} + {1'b0, tail_count_reg};
    assign room       = count_sum < (COUNT_W + 1)'(GROUP_COUNT);
    assign close_head = close_req && room && !double_reg;
    assign close_tail = close_req && room && double_reg;
    assign close_err  = close_req && !room;

    // Tail groups shift in from the top, so they already sit at their final slots.
    always_comb begin
        for (int k = 0; k < GROUP_COUNT; k++) begin
            head_closed[k] = (close_head && head_count_reg[SLOT_W-1:0] == SLOT_W'(k)) ?
                padded : head_reg[k];
            if (k == GROUP_COUNT - 1) begin
                tail_shift[k] = padded;
            end else begin
                tail_shift[k] = tail_reg[(k + 1) % GROUP_COUNT];
            end
        end
    end

    assign head_count_closed = head_count_reg + COUNT_W'(close_head);

    always_comb begin
        result.load = consume && is_newline;
        result.bad  = err_reg || close_err ||
                      (!double_reg && head_count_closed != COUNT_W'(GROUP_COUNT));
        for (int k = 0; k < GROUP_COUNT; k++) begin
            if (COUNT_W'(k) < head_count_closed) begin
                result.words[k] = head_closed[k];
            end else if (close_tail) begin
                result.words[k] = tail_shift[k];
            end else begin
                result.words[k] = tail_reg[k];
            end
        end
    end

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_count_next = head_count_reg;
        tail_count_next = tail_count_reg;
        chars_next      = chars_reg;
        len_next        = len_reg;
        prev_colon_next = prev_colon_reg;
        double_next     = double_reg;
        err_next        = err_reg;
        if (consume) begin
            if (is_newline) begin
                for (int k = 0; k < GROUP_COUNT; k++) begin
                    head_next[k] = ZERO_WORD;
                    tail_next[k] = ZERO_WORD;
                end
                head_count_next = '0;
                tail_count_next = '0;
                chars_next      = '0;
                len_next        = '0;
                prev_colon_next = 1'b0;
                double_next     = 1'b0;
                err_next        = 1'b0;
            end else if (is_colon) begin
                if (prev_colon_reg) begin
                    if (double_reg) begin
                        err_next = 1'b1;
                    end else begin
                        double_next = 1'b1;
                    end
                end else begin
                    head_next       = head_closed;
                    head_count_next = head_count_closed;
                    if (close_tail) begin
                        tail_next       = tail_shift;
                        tail_count_next = tail_count_reg + COUNT_W'(1);
                    end
                    if (close_err) begin
                        err_next = 1'b1;
                    end
                    chars_next = '0;
                    len_next   = '0;
                end
                prev_colon_next = 1'b1;
            end else begin
                if (len_reg >= LEN_W'(DIGITS_PER_GROUP)) begin
                    err_next = 1'b1;
                end else begin
                    chars_next = {chars_reg[GROUP_W-CHAR_W-1:0], in_char_reg};
                    len_next   = len_reg + LEN_W'(1);
                end
                prev_colon_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            for (int k = 0; k < GROUP_COUNT; k++) begin
                head_reg[k] <= ZERO_WORD;
                tail_reg[k] <= ZERO_WORD;
            end
            head_count_reg <= '0;
            tail_count_reg <= '0;
            chars_reg      <= '0;
            len_reg        <= '0;
            prev_colon_reg <= 1'b0;
            double_reg     <= 1'b0;
            err_reg        <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            head_count_reg <= head_count_next;
            tail_count_reg <= tail_count_next;
            chars_reg      <= chars_next;
            len_reg        <= len_next;
            prev_colon_reg <= prev_colon_next;
            double_reg     <= double_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_char;
        end
    end

    `IPV6TE_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1,
        ({1'b0, head_count_reg} + {1'b0, tail_count_reg}) <= (COUNT_W + 1)'(GROUP_COUNT))

endmodule
`default_nettype wire

@@ hdl/ipv6te_out_buffer.sv @@
// Holding buffer that delivers the groups of a finished address one per cycle while m_tready is high.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv6_text_expander_macros.svh"
module ipv6te_out_buffer
    import ipv6te_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire ipv6te_result_t  result,
    output logic                 buf_free,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [GROUP_W-1:0]   m_text,
    output logic [IDX_W-1:0]     m_index,
    output logic                 m_last,
    output logic                 m_bad
);

    logic [GROUP_COUNT-1:0][GROUP_W-1:0] words_reg;
    logic                                bad_reg;
    logic                                busy_reg, busy_next;
    logic [SLOT_W-1:0]                   idx_reg, idx_next;
    logic                                at_last, taken;

    assign at_last  = (idx_reg == SLOT_W'(GROUP_COUNT - 1));
    assign taken    = busy_reg && m_tready;
    assign buf_free = !busy_reg || (taken && at_last);

    assign m_tvalid = busy_reg;
    assign m_text   = words_reg[idx_reg];
    assign m_index  = IDX_W'(idx_reg);
    assign m_last   = at_last;
    assign m_bad    = bad_reg;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (taken) begin
            if (at_last) begin
                busy_next = 1'b0;
                idx_next  = '0;
            end else begin
                idx_next = idx_reg + SLOT_W'(1);
            end
        end
        if (result.load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.load) begin
            words_reg <= result.words;
            bad_reg   <= result.bad;
        end
    end

    `IPV6TE_ASSERT_NOW(a_load_when_free, aclk, aresetn, result.load, buf_free)
    `IPV6TE_ASSERT_NEXT(a_load_starts, aclk, aresetn, result.load,
        busy_reg && idx_reg == '0)
    `IPV6TE_ASSERT_NEXT(a_drain_ends, aclk, aresetn, taken && at_last && !result.load,
        !busy_reg)

endmodule
`default_nettype wire

@@ hdl/ipv6_text_expander.sv @@
// Top level of the IPv6 text expander.
// Takes one ASCII character of an IPv6 address per item and, on the newline,
// delivers eight items, one zero-padded four-character group each, leftmost
// first. A character is held in the input register and is then folded into
// the group state, so one character is taken every cycle unless a newline
// waits for the holding buffer. After a newline the eight groups leave one
// per cycle from a holding buffer, as long as m_tready is high, while the
// characters of the next address keep flowing in; only the next newline
// waits until the last group of the previous address has been taken.
// m_tuser flags a malformed address on all eight of its groups.
`timescale 1ns / 1ps
`default_nettype none
module ipv6_text_expander
    import ipv6te_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] char_code
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [31:0] group_text, [34:32] group_index
    output logic                    m_tlast,
    output logic                    m_tuser    // [0] malformed
);

    ipv6te_result_t     result;
    logic               buf_free;
    logic [GROUP_W-1:0] text;
    logic [IDX_W-1:0]   index;

    ipv6te_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_char   (s_tdata),
        .buf_free (buf_free),
        .result   (result)
    );

    ipv6te_out_buffer u_out_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_text   (text),
        .m_index  (index),
        .m_last   (m_tlast),
        .m_bad    (m_tuser)
    );

    assign m_tdata = {{(TDATA_W - GROUP_W - IDX_W){1'b0}}, index, text};

endmodule
`default_nettype wire

@@ dv/ipv6_group_checker.sv @@
// Checker that predicts and compares the expanded groups of the IPv6 text expander.
`timescale 1ns / 1ps
module ipv6_group_checker
    import ipv6te_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,
    input  wire logic               m_tlast,
    input  wire logic               m_tuser,
    output int                      mismatch_count,
    output int                      groups_pending,
    output int                      chars_seen,
    output int                      groups_seen,
    output int                      bad_addresses
);

    typedef struct packed {
        logic [GROUP_W-1:0] text;
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic               bad;
    } group_result_t;

    group_result_t      expected_groups[$];

    // Parser state of the predictor.
    logic [GROUP_W-1:0] head_words[GROUP_COUNT];
    logic [GROUP_W-1:0] tail_words[GROUP_COUNT];
    logic [3:0]         head_n;
    logic [3:0]         tail_n;
    logic [GROUP_W-1:0] cur_chars;
    logic [2:0]         cur_len;
    bit                 prev_colon;
    bit                 dbl_seen;
    bit                 addr_error;

    int errors;
    int n_chars;
    int n_groups;
    int n_bad;

    task automatic clear_parser();
        for (int i = 0; i < GROUP_COUNT; i++) begin
            head_words[i] = ZERO_WORD;
            tail_words[i] = ZERO_WORD;
        end
        head_n     = '0;
        tail_n     = '0;
        cur_chars  = '0;
        cur_len    = '0;
        prev_colon = 0;
        dbl_seen   = 0;
        addr_error = 0;
    endtask

    function automatic logic [GROUP_W-1:0] padded_word();
        logic [GROUP_W-1:0] mask;
        if (cur_len >= DIGITS_PER_GROUP)
            return cur_chars;
        mask = (32'h1 << (8 * cur_len)) - 32'h1;
        return (ZERO_WORD & ~mask) | (cur_chars & mask);
    endfunction

    // Groups beyond the eighth are dropped and mark the address as malformed.
    task automatic close_group();
        logic [GROUP_W-1:0] word;
        word = padded_word();
        if (int'(head_n) + int'(tail_n) >= GROUP_COUNT) begin
            addr_error = 1;
        end else if (dbl_seen) begin
            tail_words[tail_n[2:0]] = word;
            tail_n = tail_n + 4'd1;
        end else begin
            head_words[head_n[2:0]] = word;
            head_n = head_n + 4'd1;
        end
        cur_chars = '0;
        cur_len   = '0;
    endtask

    task automatic expand_char(input logic [7:0] c);
        group_result_t r;
        bit            bad;
        int            tail_start;
        if (c == CH_COLON) begin
            if (prev_colon) begin
                if (dbl_seen)
                    addr_error = 1;
                else
                    dbl_seen = 1;
            end else begin
                close_group();
            end
            prev_colon = 1;
        end else if (c != CH_NEWLINE) begin
            if (cur_len >= DIGITS_PER_GROUP) begin
                addr_error = 1;
            end else begin
                cur_chars = {cur_chars[GROUP_W-9:0], c};
                cur_len   = cur_len + 3'd1;
            end
            prev_colon = 0;
        end else begin
            // A trailing double colon leaves no empty group to close.
            if (!(dbl_seen && prev_colon))
                close_group();
            bad = addr_error || (!dbl_seen && int'(head_n) != GROUP_COUNT);
            tail_start = GROUP_COUNT - int'(tail_n);
            for (int k = 0; k < GROUP_COUNT; k++) begin
                if (k < int'(head_n))
                    r.text = head_words[k];
                else if (k >= tail_start)
                    r.text = tail_words[k - tail_start];
                else
                    r.text = ZERO_WORD;
                r.idx  = k[IDX_W-1:0];
                r.last = (k == GROUP_COUNT - 1);
                r.bad  = bad;
                expected_groups.push_back(r);
            end
            clear_parser();
        end
    endtask

    always @(posedge aclk) begin
        group_result_t exp_g;
        logic [TDATA_W-1:GROUP_W+IDX_W] pad;
        if (!aresetn) begin
            clear_parser();
            expected_groups.delete();
            errors   = 0;
            n_chars  = 0;
            n_groups = 0;
            n_bad    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_groups++;
                pad = m_tdata[TDATA_W-1:GROUP_W+IDX_W];
                if (expected_groups.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected group item text %h idx %0d last %b bad %b",
                                 $realtime, m_tdata[GROUP_W-1:0],
                                 m_tdata[GROUP_W+IDX_W-1:GROUP_W], m_tlast, m_tuser);
                end else begin
                    exp_g = expected_groups.pop_front();
                    if (exp_g.last && exp_g.bad)
                        n_bad++;
                    if (m_tdata[GROUP_W-1:0] !== exp_g.text ||
                        m_tdata[GROUP_W+IDX_W-1:GROUP_W] !== exp_g.idx ||
                        m_tlast !== exp_g.last || m_tuser !== exp_g.bad || pad !== '0) begin
                        errors++;
                        if (errors <= 10) begin
                            $write("%0t: group mismatch: expected text %h idx %0d last %b bad %b,",
                                   $realtime, exp_g.text, exp_g.idx, exp_g.last, exp_g.bad);
                            $display(" got text %h idx %0d last %b bad %b pad %h",
                                     m_tdata[GROUP_W-1:0], m_tdata[GROUP_W+IDX_W-1:GROUP_W],
                                     m_tlast, m_tuser, pad);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                n_chars++;
                expand_char(s_tdata);
            end
        end
        mismatch_count <= errors;
        groups_pending <= expected_groups.size();
        chars_seen     <= n_chars;
        groups_seen    <= n_groups;
        bad_addresses  <= n_bad;
    end

endmodule

@@ dv/ipv6_text_expander_tb.sv @@
// Testbench top of the IPv6 text expander: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module ipv6_text_expander_tb;
    import ipv6te_pkg::*;

    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_CHARS  = 80;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    int mismatch_count;
    int groups_pending;
    int chars_seen;
    int groups_seen;
    int bad_addresses;

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int stall_cycles;

    always #4 aclk = ~aclk;

    ipv6_text_expander u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    ipv6_group_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .groups_pending (groups_pending),
        .chars_seen     (chars_seen),
        .groups_seen    (groups_seen),
        .bad_addresses  (bad_addresses)
    );

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] any_char();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_NEWLINE);
        return b;
    endfunction

    // Mostly hex digits of both cases; now and then any byte that is not a separator.
    function automatic logic [7:0] group_char();
        int         v;
        logic [7:0] b;
        if ($urandom_range(99) < 85) begin
            v = $urandom_range(21);
            if (v < 10)
                return CH_ZERO + v[7:0];
            else if (v < 16)
                return 8'h61 + v[7:0] - 8'd10;
            else
                return 8'h41 + v[7:0] - 8'd16;
        end
        do b = any_char(); while (b == CH_COLON);
        return b;
    endfunction

    task automatic push_group(input int max_len, ref logic [7:0] text[$]);
        int n;
        n = $urandom_range(1, max_len);
        for (int i = 0; i < n; i++)
            text.push_back(group_char());
    endtask

    task automatic build_address(input int heads, input int tails, input bit dbl,
                                 input int max_len, ref logic [7:0] text[$]);
        for (int i = 0; i < heads; i++) begin
            if (i > 0)
                text.push_back(CH_COLON);
            push_group(max_len, text);
        end
        if (dbl) begin
            text.push_back(CH_COLON);
            text.push_back(CH_COLON);
            for (int i = 0; i < tails; i++) begin
                if (i > 0)
                    text.push_back(CH_COLON);
                push_group(max_len, text);
            end
        end
        text.push_back(CH_NEWLINE);
    endtask

    task automatic random_address(ref logic [7:0] text[$]);
        int r;
        int g;
        int h;
        r = $urandom_range(99);
        if (r < 65) begin
            if ($urandom_range(2) == 0) begin
                build_address(8, 0, 0, 4, text);
            end else begin
                g = $urandom_range(0, 8);
                h = $urandom_range(0, g);
                build_address(h, g - h, 1, 4, text);
            end
        end else if (r < 85) begin
            case ($urandom_range(2))
                0: build_address($urandom_range(1) ? 7 : 9, 0, 0, 4, text);
                1: build_address(8, 0, 0, 7, text);
                default: begin
                    g = $urandom_range(9, 10);
                    h = $urandom_range(0, g);
                    build_address(h, g - h, 1, 4, text);
                end
            endcase
        end else begin
            g = $urandom_range(1, 24);
            for (int i = 0; i < g; i++)
                text.push_back(($urandom_range(99) < 25) ? CH_COLON : any_char());
            text.push_back(CH_NEWLINE);
        end
    endtask

    task automatic run_random_phase(input int target);
        logic [7:0] text[$];
        int         sent;
        sent = 0;
        while (sent < target) begin
            text.delete();
            random_address(text);
            sent += text.size();
            foreach (text[i])
                send_char(text[i]);
        end
    endtask

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ipv6_text_expander_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tx_idle_pct = 15;
        rx_idle_pct = 84;
        hold_req    = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty address, then a second double colon.
        send_string("\n");
        send_string(":::\n");
        // Extreme bytes in an overlong group, trailing single colon, too few groups.
        send_char(8'h00);
        send_char(8'hFF);
        send_string("aBc:\n");
        // Leading colon and a trailing double colon.
        send_string(":1::\n");
        // Nine groups, the last an empty one after the trailing colon.
        send_string("1:2:3:4:5:6:7:8:\n");

        run_random_phase(PHASE_CHARS);
        tx_idle_pct = 84;
        rx_idle_pct = 15;
        run_random_phase(PHASE_CHARS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1;
        run_random_phase(PHASE_CHARS);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (groups_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d characters and %0d groups, %0d addresses flagged malformed",
                 chars_seen, groups_seen, bad_addresses);
        $display("flow control: sender-heavy, receiver-heavy and free-running idling,");
        $display("plus a %0d-cycle output hold-off while input kept coming", HOLD_CYCLES);
        if (mismatch_count == 0 && groups_pending == 0)
            $display("ipv6_text_expander_tb: done, clean");
        else
            $display("ipv6_text_expander_tb: done, errors");
        $finish;
    end

endmodule
